// ===== hdl/imh_pkg.sv =====
// Package for the indexed min-heap: widths, commands, status codes, FSM states.
// No dependencies.
package imh_pkg;

    localparam int CAPACITY_DEF     = 1024;
    localparam int HANDLE_LIMIT_DEF = 1024;
    localparam int VAL_W = 32;
    localparam int HW    = 11;

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_PEEK   = 3'd1,
        CMD_DELMIN = 3'd2,
        CMD_DELH   = 3'd3,
        CMD_MODH   = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_BADH  = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_HRD,        // read handle_position / live for handle command
        S_HCHK,
        S_INS,
        S_DM_RD1,     // read slot p (slot 1, or the handle's slot)
        S_DM_RD2,
        S_DM_WR,
        S_DM_WR2,
        S_MOD_WR,
        S_SD_RD,      // sift down: read parent
        S_SD_RDL,
        S_SD_RDR,
        S_SD_CMP,
        S_SU_RD,      // sift up: read node and parent
        S_SU_RDP,
        S_SU_CMP,
        S_SW_A,       // swap: write slot a
        S_SW_B,
        S_MINRD,
        S_MINWAIT,
        S_OUT
    } state_t;

    // swap command between sequencer phases
    typedef struct packed {
        logic        up;   // return to sift up after swap
    } swap_ctl_t;

endpackage

// ===== hdl/imh_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module imh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/indexed_min_heap.sv =====
// Indexed binary min-heap top level: command sequencer over heap memories.
// Depends on imh_pkg and imh_ram.
//
//  channel | dir | tdata fields (low bit up)            | tuser
//  s_axis  | in  | cmd[2:0] value[34:3] handle[45:35]    | -
//  m_axis  | out | status[1:0] min_value[33:2]          | -
//          |     | heap_empty[34] new_handle[45:35] count[56:46] |
//
// One command at a time. A sift-down level reads node, left and right child
// through the one read port of the heap memory, then compares, and a swap
// writes slot a and then slot b; a sift-up level reads node and parent, then
// compares, and may swap the same way.
// Reset clears state, sizes and output valid only; the handle live bits sit in
// a RAM and are trusted only for handles already issued, each of which was written at its insert.
// The result sits in an output register; the next command is taken once it is
// consumed.
module indexed_min_heap
    import imh_pkg::*;
#(
    parameter int CAPACITY     = CAPACITY_DEF,
    parameter int HANDLE_LIMIT = HANDLE_LIMIT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // cmd, value, handle
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // status, min_value, heap_empty, new_handle, count
);
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int HDW = $clog2(HANDLE_LIMIT + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int HAW = $clog2(HANDLE_LIMIT);

    state_t state_reg, state_next;

    logic [2:0]       cmd_reg;
    logic [VAL_W-1:0] val_reg;
    logic [HW-1:0]    h_reg;
    logic [PW-1:0]    size_reg;
    logic [HDW-1:0]   used_reg;
    logic [PW-1:0]    u_reg, a_reg, b_reg, p_reg;
    logic [VAL_W-1:0] va_reg, vb_reg, vbest_reg, vmin_reg;
    logic [PW-1:0]    best_reg;
    logic [HDW-1:0]   ha_reg, hb_reg;
    logic             back_up_reg;  // after sift down, continue with sift up
    logic             ret_up_reg;   // swap returns to sift up
    logic [1:0]       status_reg;
    logic [HW-1:0]    newh_reg;
    logic             ovalid_reg;

    // memories: values and position->handle share addressing; handle->position
    logic             v_we;
    logic [AW-1:0]    v_wa, v_ra;
    logic [VAL_W-1:0] v_wd, v_rd;
    logic [HDW-1:0]   ph_wd, ph_rd;
    logic             hp_we;
    logic [HAW-1:0]   hp_wa, hp_ra;
    logic [PW-1:0]    hp_wd, hp_rd;
    logic             lv_we, lv_wd, lv_rd;
    logic [HAW-1:0]   lv_wa;

    imh_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val (
        .clk, .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd));
    imh_ram #(.WIDTH(HDW), .DEPTH(CAPACITY)) u_ph (
        .clk, .we(v_we), .waddr(v_wa), .wdata(ph_wd), .raddr(v_ra), .rdata(ph_rd));
    imh_ram #(.WIDTH(PW), .DEPTH(HANDLE_LIMIT)) u_hp (
        .clk, .we(hp_we), .waddr(hp_wa), .wdata(hp_wd), .raddr(hp_ra), .rdata(hp_rd));
    imh_ram #(.WIDTH(1), .DEPTH(HANDLE_LIMIT)) u_live (
        .clk, .we(lv_we), .waddr(lv_wa), .wdata(lv_wd), .raddr(hp_ra), .rdata(lv_rd));

    // slot p (1-based) lives at address p-1
    function automatic logic [AW-1:0] sa(input logic [PW-1:0] p);
        logic [PW-1:0] t;
        t = p - PW'(1);
        return t[AW-1:0];
    endfunction
    function automatic logic [HAW-1:0] ha(input logic [HDW-1:0] h);
        logic [HDW-1:0] t;
        t = h - HDW'(1);
        return t[HAW-1:0];
    endfunction

    logic [HDW-1:0] hin;
    logic           h_ok;
    assign hin  = HDW'(h_reg);
    // live bit is only trusted once the handle is known to be issued
    assign h_ok = (h_reg != '0) && ({{(HW+HDW){1'b0}}, h_reg} <= {{HW{1'b0}}, used_reg, {HW{1'b0}}} >> HW)
                  && lv_rd;

    logic [PW:0] lchild, rchild;
    assign lchild = {u_reg, 1'b0};
    assign rchild = {u_reg, 1'b1};
    logic l_in, r_in, r_less;
    assign l_in = lchild <= {1'b0, size_reg};
    assign r_in = rchild <= {1'b0, size_reg};
    assign r_less = r_in && ($signed(v_rd) < $signed(vbest_reg));

    assign s_axis_tready = (state_reg == S_IDLE) && !ovalid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    priority case (s_axis_tdata[2:0])
                        CMD_INSERT:             state_next = S_INS;
                        CMD_DELMIN:             state_next = S_DM_RD1;
                        CMD_DELH, CMD_MODH:     state_next = S_HRD;
                        default:                state_next = S_MINRD;
                    endcase
                end
            end
            S_HRD:     state_next = S_HCHK;
            S_HCHK:    state_next = !h_ok ? S_MINRD : (cmd_reg == CMD_MODH ? S_MOD_WR
                                                       : S_DM_RD1);
            S_INS:     state_next = (size_reg >= PW'(CAPACITY) || used_reg >= HDW'(HANDLE_LIMIT))
                                    ? S_MINRD : S_SU_RD;
            S_DM_RD1:  state_next = (size_reg == '0) ? S_MINRD : S_DM_RD2;
            S_DM_RD2:  state_next = S_DM_WR;
            S_DM_WR:   state_next = S_DM_WR2;
            S_DM_WR2:  state_next = (p_reg < size_reg) ? S_SD_RD : S_MINRD;
            S_MOD_WR:  state_next = S_SD_RD;
            S_SD_RD:   state_next = S_SD_RDL;
            S_SD_RDL:  state_next = S_SD_RDR;
            S_SD_RDR:  state_next = S_SD_CMP;
            S_SD_CMP:  state_next = (r_less || best_reg != u_reg) ? S_SW_A
                                    : (back_up_reg ? S_SU_RD : S_MINRD);
            S_SU_RD:   state_next = (u_reg <= PW'(1)) ? S_MINRD : S_SU_RDP;
            S_SU_RDP:  state_next = S_SU_CMP;
            S_SU_CMP:  state_next = ($signed(v_rd) > $signed(vb_reg)) ? S_SW_A : S_MINRD;
            S_SW_A:    state_next = S_SW_B;
            S_SW_B:    state_next = ret_up_reg ? S_SU_RD : S_SD_RD;
            S_MINRD:   state_next = S_MINWAIT;
            S_MINWAIT: state_next = S_OUT;
            S_OUT:     state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // memory ports
    always_comb
    begin
        v_we  = 1'b0;
        v_wa  = sa(a_reg);
        v_wd  = vb_reg;
        ph_wd = hb_reg;
        v_ra  = sa(u_reg);
        hp_we = 1'b0;
        hp_wa = ha(hb_reg);
        hp_wd = a_reg;
        hp_ra = ha(hin);
        lv_we = 1'b0;
        lv_wa = ha(hin);
        lv_wd = 1'b0;
        unique case (state_reg)
            S_INS:
            begin
                v_we  = !(size_reg >= PW'(CAPACITY) || used_reg >= HDW'(HANDLE_LIMIT));
                v_wa  = sa(size_reg + PW'(1));
                v_wd  = val_reg;
                ph_wd = used_reg + HDW'(1);
                hp_we = v_we;
                hp_wa = ha(used_reg + HDW'(1));
                hp_wd = size_reg + PW'(1);
                lv_we = v_we;
                lv_wa = ha(used_reg + HDW'(1));
                lv_wd = 1'b1;
            end
            S_HCHK:    lv_we = h_ok && (cmd_reg == CMD_DELH);
            S_DM_RD1:  v_ra = sa(p_reg);
            S_DM_RD2:
            begin
                v_ra  = sa(size_reg);
                lv_we = (cmd_reg == CMD_DELMIN);
                lv_wa = ha(ph_rd);
            end
            S_DM_WR:
            begin
                // last slot's contents arrive this cycle
                v_we = 1'b1; hp_we = 1'b1;
                v_wd = v_rd; ph_wd = ph_rd; hp_wa = ha(ph_rd);
            end
            S_SW_A:
            begin
                v_we = 1'b1; hp_we = 1'b1;   // slot a <= b's contents
            end
            S_DM_WR2, S_SW_B:
            begin
                v_we = 1'b1; hp_we = 1'b1;
                v_wa = sa(b_reg); v_wd = va_reg; ph_wd = ha_reg;
                hp_wa = ha(ha_reg); hp_wd = b_reg;
            end
            S_MOD_WR:
            begin
                v_we = 1'b1; v_wa = sa(p_reg); v_wd = val_reg; ph_wd = ha_reg;
            end
            S_SD_RD:   v_ra = sa(u_reg);
            S_SD_RDL:  v_ra = sa(lchild[PW-1:0]);
            S_SD_RDR:  v_ra = sa(rchild[PW-1:0]);
            S_SU_RD:   v_ra = sa(u_reg);
            S_SU_RDP:  v_ra = sa(u_reg >> 1);
            S_MINRD:   v_ra = sa(PW'(1));
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            size_reg   <= '0;
            used_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (m_axis_tvalid && m_axis_tready)
            begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_INS:
                begin
                    if (!(size_reg >= PW'(CAPACITY) || used_reg >= HDW'(HANDLE_LIMIT)))
                    begin
                        size_reg <= size_reg + PW'(1);
                        used_reg <= used_reg + HDW'(1);
                    end
                end
                S_DM_WR2:  size_reg <= size_reg - PW'(1);
                S_OUT:     ovalid_reg <= 1'b1;
                default:   ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    cmd_reg     <= s_axis_tdata[2:0];
                    val_reg     <= s_axis_tdata[34:3];
                    h_reg       <= s_axis_tdata[45:35];
                    newh_reg    <= '0;
                    back_up_reg <= 1'b0;
                    p_reg       <= PW'(1);
                    priority case (s_axis_tdata[2:0])
                        CMD_INSERT, CMD_DELMIN, CMD_DELH, CMD_MODH: status_reg <= ST_OK;
                        default: status_reg <= (size_reg == '0) ? ST_EMPTY : ST_OK;
                    endcase
                end
            end
            S_HCHK:
            begin
                p_reg  <= hp_rd;
                u_reg  <= hp_rd;
                ha_reg <= hin;
                back_up_reg <= 1'b1;
                if (!h_ok)
                begin
                    status_reg <= ST_BADH;
                end
            end
            S_INS:
            begin
                if (size_reg >= PW'(CAPACITY) || used_reg >= HDW'(HANDLE_LIMIT))
                begin
                    status_reg <= ST_FULL;
                end
                else
                begin
                    newh_reg <= HW'(used_reg + HDW'(1));
                    u_reg    <= size_reg + PW'(1);
                    vb_reg   <= val_reg;
                end
            end
            S_DM_RD1:
            begin
                if (size_reg == '0)
                begin
                    status_reg <= ST_EMPTY;
                end
                a_reg <= p_reg;
                b_reg <= size_reg;
                u_reg <= p_reg;
            end
            S_DM_RD2:
            begin
                va_reg <= v_rd; ha_reg <= ph_rd;
            end
            S_DM_WR:
            begin
                vb_reg <= v_rd; hb_reg <= ph_rd;
            end
            S_SD_RDL:
            begin
                vbest_reg <= v_rd; va_reg <= v_rd; ha_reg <= ph_rd;
                best_reg  <= u_reg; a_reg <= u_reg;
            end
            S_SD_RDR:
            begin
                if (l_in && $signed(v_rd) < $signed(vbest_reg))
                begin
                    vbest_reg <= v_rd; best_reg <= lchild[PW-1:0];
                    vb_reg <= v_rd; hb_reg <= ph_rd;
                end
            end
            S_SD_CMP:
            begin
                ret_up_reg <= 1'b0;
                if (r_less)
                begin
                    best_reg <= rchild[PW-1:0];
                    b_reg <= rchild[PW-1:0];
                    vb_reg <= v_rd; hb_reg <= ph_rd;
                    u_reg <= rchild[PW-1:0];
                end
                else if (best_reg != u_reg)
                begin
                    b_reg <= best_reg; u_reg <= best_reg;
                end
            end
            S_SU_RDP:
            begin
                vb_reg <= v_rd; hb_reg <= ph_rd;
                b_reg  <= u_reg;
            end
            S_SU_CMP:
            begin
                ret_up_reg <= 1'b1;
                // a = parent (gets child's contents), b = child
                a_reg  <= u_reg >> 1;
                va_reg <= v_rd; ha_reg <= ph_rd;
                u_reg  <= u_reg >> 1;
            end
            S_MINWAIT: vmin_reg <= v_rd;
            default:   ;
        endcase
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = {7'd0, HW'(size_reg), newh_reg, (size_reg == '0),
                           (size_reg == '0) ? {VAL_W{1'b0}} : vmin_reg, status_reg};
endmodule

// ===== hdl/imh_checker.sv =====
// Port-level checker for indexed_min_heap, bound to the top level.
// Depends on imh_pkg.
module imh_checker
    import imh_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);
    // no new command while a result waits
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("ready with result pending");
    // empty flag agrees with count
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[34] == (m_axis_tdata[56:46] == '0)))
        else $error("empty flag mismatch");
    // empty heap shows minimum zero
    a_minz: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[34]) |-> (m_axis_tdata[33:2] == '0))
        else $error("nonzero min on empty");
    // new handle only with ok status
    a_nh: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[45:35] != '0) |-> (m_axis_tdata[1:0] == ST_OK))
        else $error("handle with error status");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
endmodule

bind indexed_min_heap imh_checker u_imh_checker (.*);
